@@ src/bmcs_pkg.sv @@
// Shared constants and types for the binary mask confusion statistics block.
// Used by the interfaces, the controller, the datapath and the divider.
// Depends on nothing.
package bmcs_pkg;

  // Counter and fraction sizing.
  localparam int COUNT_BITS    = 24;
  localparam int FRACTION_BITS = 16;

  // Widths of the result fields on the output channel.
  localparam int CNT_OUT_W   = 24;
  localparam int RATIO_OUT_W = 17;
  localparam int PIX_W       = 8;

  // The F1 denominator 2TP + FP + FN needs two bits more than one count.
  localparam int DEN_BITS  = COUNT_BITS + 2;
  // A ratio of at most 1.0 has one integer bit plus the fraction bits.
  localparam int QUO_BITS  = FRACTION_BITS + 1;
  localparam int STEP_BITS = $clog2(QUO_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PIX_W-1:0]      PIX_ZERO  = '0;
  localparam logic [PIX_W-1:0]      PIX_FULL  = {PIX_W{1'b1}};

  // Which ratio the shared divider works on.
  typedef enum logic [1:0] {
    SEL_SENS,
    SEL_SPEC,
    SEL_F1
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     count;
    logic     close;
    logic     div_start;
    div_sel_e div_sel;
    logic     res_store;
    logic     out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/bmcs_if.sv @@
// Valid/ready channel interfaces for pixel pairs and frame results.
// Depends on bmcs_pkg for the field widths.

// Pixel pair channel.
interface bmcs_pix_if;
  logic                          valid;
  logic                          ready;
  logic [bmcs_pkg::PIX_W-1:0]    reference_pixel;
  logic [bmcs_pkg::PIX_W-1:0]    test_pixel;
  logic                          frame_end;

  modport source (output valid, reference_pixel, test_pixel, frame_end, input ready);
  modport sink   (input valid, reference_pixel, test_pixel, frame_end, output ready);
endinterface

// Frame result channel.
interface bmcs_res_if;
  logic                              valid;
  logic                              ready;
  logic [bmcs_pkg::CNT_OUT_W-1:0]    true_pos;
  logic [bmcs_pkg::CNT_OUT_W-1:0]    false_pos;
  logic [bmcs_pkg::CNT_OUT_W-1:0]    false_neg;
  logic [bmcs_pkg::CNT_OUT_W-1:0]    true_neg;
  logic [bmcs_pkg::RATIO_OUT_W-1:0]  balanced_accuracy;
  logic [bmcs_pkg::RATIO_OUT_W-1:0]  f1_score;
  logic                              accuracy_undefined;
  logic                              f1_undefined;
  logic                              count_saturated;

  modport source (output valid, true_pos, false_pos, false_neg, true_neg,
                  balanced_accuracy, f1_score, accuracy_undefined, f1_undefined,
                  count_saturated, input ready);
  modport sink   (input valid, true_pos, false_pos, false_neg, true_neg,
                  balanced_accuracy, f1_score, accuracy_undefined, f1_undefined,
                  count_saturated, output ready);
endinterface

@@ src/bmcs_divider.sv @@
// Bit-serial restoring divider producing floor(num * 2^FRACTION_BITS / den).
// Assumes num <= den, so the quotient fits in QUO_BITS. Depends on bmcs_pkg.
module bmcs_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bmcs_pkg::DEN_BITS-1:0]  num_i,
  input  logic [bmcs_pkg::DEN_BITS-1:0]  den_i,
  output logic                           done_o,
  output logic [bmcs_pkg::QUO_BITS-1:0]  quo_o
);

  localparam int DW = bmcs_pkg::DEN_BITS;
  localparam int QW = bmcs_pkg::QUO_BITS;
  localparam int SW = bmcs_pkg::STEP_BITS;
  localparam logic [SW-1:0] STEP_LAST = SW'(QW - 1);

  logic          busy_q;
  logic          done_q;
  logic [SW-1:0] step_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q;

  logic          ge;
  logic [DW:0]   diff;

  // One quotient bit per cycle: compare, subtract, shift.
  always_comb begin
    ge   = (rem_q >= {1'b0, den_q});
    diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + SW'(1);
        if (step_q == STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= {diff[DW-1:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ src/bmcs_datapath.sv @@
// Datapath: confusion counters, frame snapshot, ratio results and output register.
// Depends on bmcs_pkg, bmcs_res_if and bmcs_divider.
module bmcs_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bmcs_pkg::PIX_W-1:0]   reference_pixel_i,
  input  logic [bmcs_pkg::PIX_W-1:0]   test_pixel_i,
  input  bmcs_pkg::ctrl_cmd_t          cmd_i,
  output bmcs_pkg::dp_stat_t           stat_o,
  bmcs_res_if.source                   res_o
);

  localparam int CW = bmcs_pkg::COUNT_BITS;
  localparam int DW = bmcs_pkg::DEN_BITS;
  localparam int QW = bmcs_pkg::QUO_BITS;

  logic [CW-1:0] tp_q, fp_q, fn_q, tn_q;
  logic          sat_q;
  logic [CW-1:0] tp_d, fp_d, fn_d, tn_d;
  logic          sat_d;

  logic [CW-1:0] snap_tp_q, snap_fp_q, snap_fn_q, snap_tn_q;
  logic          snap_sat_q;

  logic [QW-1:0] sens_q;
  logic [QW-1:0] ba_q;
  logic [QW-1:0] f1_q;
  logic [QW:0]   ba_sum;

  logic [CW:0]   tp_fn;
  logic [CW:0]   tn_fp;
  logic [DW-1:0] f1_den;
  logic [DW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [QW-1:0] div_quo;
  logic          acc_undef;
  logic          f1_undef;
  logic          out_valid_q;

  // Saturating increment of a count.
  function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
    return (c < bmcs_pkg::COUNT_MAX) ? c + CW'(1) : c;
  endfunction

  // Next counter values for the current pixel pair.
  always_comb begin
    tp_d = tp_q;
    fp_d = fp_q;
    fn_d = fn_q;
    tn_d = tn_q;
    if (reference_pixel_i == bmcs_pkg::PIX_ZERO) begin
      if (test_pixel_i == bmcs_pkg::PIX_ZERO) tp_d = bump(tp_q);
      else                                    fp_d = bump(fp_q);
    end else begin
      if (test_pixel_i == bmcs_pkg::PIX_FULL) tn_d = bump(tn_q);
      else                                    fn_d = bump(fn_q);
    end
    sat_d = sat_q || (tp_d == bmcs_pkg::COUNT_MAX) || (fp_d == bmcs_pkg::COUNT_MAX) ||
            (fn_d == bmcs_pkg::COUNT_MAX) || (tn_d == bmcs_pkg::COUNT_MAX);
  end

  // Running counters; cleared after the last pixel of a frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q  <= '0;
      fp_q  <= '0;
      fn_q  <= '0;
      tn_q  <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.close) begin
      tp_q  <= '0;
      fp_q  <= '0;
      fn_q  <= '0;
      tn_q  <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.count) begin
      tp_q  <= tp_d;
      fp_q  <= fp_d;
      fn_q  <= fn_d;
      tn_q  <= tn_d;
      sat_q <= sat_d;
    end
  end

  // Snapshot of the closed frame, including its last pixel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      snap_tp_q  <= tp_d;
      snap_fp_q  <= fp_d;
      snap_fn_q  <= fn_d;
      snap_tn_q  <= tn_d;
      snap_sat_q <= sat_d;
    end
  end

  // Denominators and operand selection for the shared divider.
  always_comb begin
    tp_fn  = {1'b0, snap_tp_q} + {1'b0, snap_fn_q};
    tn_fp  = {1'b0, snap_tn_q} + {1'b0, snap_fp_q};
    f1_den = {1'b0, snap_tp_q, 1'b0} + DW'(snap_fp_q) + DW'(snap_fn_q);
    unique case (cmd_i.div_sel)
      bmcs_pkg::SEL_SENS: begin
        div_num = DW'(snap_tp_q);
        div_den = DW'(tp_fn);
      end
      bmcs_pkg::SEL_SPEC: begin
        div_num = DW'(snap_tn_q);
        div_den = DW'(tn_fp);
      end
      bmcs_pkg::SEL_F1: begin
        div_num = {1'b0, snap_tp_q, 1'b0};
        div_den = f1_den;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
    acc_undef = (tp_fn == '0) || (tn_fp == '0);
    f1_undef  = (snap_tp_q == '0);
    ba_sum    = {1'b0, sens_q} + {1'b0, div_quo};
  end

  bmcs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Ratio results as each division finishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_store) begin
      case (cmd_i.div_sel)
        bmcs_pkg::SEL_SENS: sens_q <= div_quo;
        bmcs_pkg::SEL_SPEC: ba_q   <= ba_sum[QW:1];
        default:            f1_q   <= div_quo;
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_o.true_pos           <= bmcs_pkg::CNT_OUT_W'(snap_tp_q);
      res_o.false_pos          <= bmcs_pkg::CNT_OUT_W'(snap_fp_q);
      res_o.false_neg          <= bmcs_pkg::CNT_OUT_W'(snap_fn_q);
      res_o.true_neg           <= bmcs_pkg::CNT_OUT_W'(snap_tn_q);
      res_o.balanced_accuracy  <= acc_undef ? '0 : bmcs_pkg::RATIO_OUT_W'(ba_q);
      res_o.f1_score           <= f1_undef ? '0 : bmcs_pkg::RATIO_OUT_W'(f1_q);
      res_o.accuracy_undefined <= acc_undef;
      res_o.f1_undefined       <= f1_undef;
      res_o.count_saturated    <= snap_sat_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || res_o.ready;

endmodule

@@ src/bmcs_ctrl.sv @@
// Controller: pixel acceptance, division sequencing and result hand-off.
// Depends on bmcs_pkg.
module bmcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 frame_end_i,
  output logic                 in_ready_o,
  input  bmcs_pkg::dp_stat_t   stat_i,
  output bmcs_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e             state_q, state_d;
  bmcs_pkg::div_sel_e sel_q, sel_d;
  logic               issue_q, issue_d;
  logic               accept;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    issue_d = 1'b0;
    accept  = 1'b0;
    cmd_o   = '0;
    cmd_o.div_sel   = sel_q;
    cmd_o.div_start = issue_q;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_COUNT: begin
        in_ready_o  = 1'b1;
        accept      = in_valid_i;
        cmd_o.count = accept;
        cmd_o.close = accept && frame_end_i;
        if (accept && frame_end_i) begin
          state_d = ST_DIV;
          sel_d   = bmcs_pkg::SEL_SENS;
          issue_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.res_store = 1'b1;
          unique case (sel_q)
            bmcs_pkg::SEL_SENS: begin
              sel_d   = bmcs_pkg::SEL_SPEC;
              issue_d = 1'b1;
            end
            bmcs_pkg::SEL_SPEC: begin
              sel_d   = bmcs_pkg::SEL_F1;
              issue_d = 1'b1;
            end
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_OUT: begin
        cmd_o.out_load = stat_i.out_free;
        if (stat_i.out_free) state_d = ST_COUNT;
      end
      default: state_d = ST_COUNT;
    endcase
  end

  // State and sequencing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COUNT;
      sel_q   <= bmcs_pkg::SEL_SENS;
      issue_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      issue_q <= issue_d;
    end
  end

endmodule

@@ src/binary_mask_confusion_stats_unit.sv @@
// Binary mask confusion statistics: counts pixel pairs of a frame into four
// bins and reports the counts, balanced accuracy and F1 at frame end.
//
// Channels: pix_i takes one pixel pair per beat (reference, test, frame_end);
// res_o gives one result beat per frame. A beat moves when valid and ready
// are both high.
// Throughput: one pixel beat per cycle while counting. The beat flagged
// frame_end closes the frame; the three ratios then run one after another
// on a shared bit-serial divider, and pix_i is not ready during that time.
// The result beat becomes valid in the same cycle in which pixel beats
// are accepted again.
// Stalls: the result sits in an output register; pixels of the next frame
// keep streaming while it waits. A further frame end holds pix_i off past
// its divisions only while its result would overwrite one still not taken.
// Reset: counters, saturation flag and the output valid clear at once;
// the block accepts pixels from the first cycle after reset.
// Depends on bmcs_pkg, bmcs_if, bmcs_ctrl, bmcs_datapath and bmcs_divider.
module binary_mask_confusion_stats_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmcs_pix_if.sink   pix_i,
  bmcs_res_if.source res_o
);

  bmcs_pkg::ctrl_cmd_t cmd;
  bmcs_pkg::dp_stat_t  stat;

  // Sequencing of counting, division and result hand-off.
  bmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .frame_end_i (pix_i.frame_end),
    .in_ready_o  (pix_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Counters, divider and result registers.
  bmcs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .reference_pixel_i (pix_i.reference_pixel),
    .test_pixel_i      (pix_i.test_pixel),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .res_o             (res_o)
  );

endmodule

@@ tb/sv/binary_mask_confusion_stats_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for binary_mask_confusion_stats_unit: streams pixel pairs,
// predicts each frame's counts, balanced accuracy and F1, and checks every result beat.
// Depends on bmcs_pkg, the bmcs_pix_if and bmcs_res_if interfaces and the RTL top level.
module binary_mask_confusion_stats_unit_test;

  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_PIXELS = 1500;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 3 * (bmcs_pkg::FRACTION_BITS + 3) + 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic [bmcs_pkg::PIX_W-1:0] ref_px;
    logic [bmcs_pkg::PIX_W-1:0] test_px;
    logic                       last;
  } pixel_pair_t;

  typedef struct {
    logic [bmcs_pkg::CNT_OUT_W-1:0]   tp;
    logic [bmcs_pkg::CNT_OUT_W-1:0]   fp;
    logic [bmcs_pkg::CNT_OUT_W-1:0]   fn;
    logic [bmcs_pkg::CNT_OUT_W-1:0]   tn;
    logic [bmcs_pkg::RATIO_OUT_W-1:0] bal_acc;
    logic [bmcs_pkg::RATIO_OUT_W-1:0] f1;
    logic                             acc_undef;
    logic                             f1_undef;
    logic                             saturated;
  } frame_stats_t;

  typedef enum {FRAME_MASK, FRAME_NOISE} frame_style_e;
  typedef enum {PACE_FULL, PACE_HALF, PACE_SPARSE} pace_e;

  logic clk_i;
  logic rst_ni;

  bmcs_pix_if pix_if ();
  bmcs_res_if res_if ();

  binary_mask_confusion_stats_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .res_o  (res_if)
  );

  // Pixel pairs waiting to be driven and frame results waiting to arrive.
  pixel_pair_t  pending_pairs[$];
  frame_stats_t expected_stats[$];

  // Running confusion counts of the frame in progress.
  logic [bmcs_pkg::COUNT_BITS-1:0] tp_cnt, fp_cnt, fn_cnt, tn_cnt;
  logic                            sat_seen;

  int    mismatches, frames_checked, pixels_counted, cycle_count;
  int    acc_undef_frames, f1_undef_frames, input_stall_cycles;
  int    res_wait, longest_res_wait;
  int    burst_left, gap_left, hold_left, pace_left;
  logic  pix_taken;
  logic  first_hold_done, second_hold_done;
  pace_e pace_mode;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reset and known values on every input from time zero.
  initial begin
    rst_ni                 = 1'b0;
    pix_if.valid           = 1'b0;
    pix_if.reference_pixel = '0;
    pix_if.test_pixel      = '0;
    pix_if.frame_end       = 1'b0;
    res_if.ready           = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic logic [bmcs_pkg::COUNT_BITS-1:0] bump_count(
      input logic [bmcs_pkg::COUNT_BITS-1:0] c);
    return (c == bmcs_pkg::COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic longint unsigned q_ratio(input longint unsigned num,
                                              input longint unsigned den);
    return (den == 0) ? 0 : (num << bmcs_pkg::FRACTION_BITS) / den;
  endfunction

  // Count one accepted pair; on the frame's last pixel, queue the expected result.
  task automatic count_pair(input pixel_pair_t p);
    frame_stats_t      s;
    longint unsigned   tp, fp, fn, tn;
    if (p.ref_px == bmcs_pkg::PIX_ZERO) begin
      if (p.test_px == bmcs_pkg::PIX_ZERO) tp_cnt = bump_count(tp_cnt);
      else                                 fp_cnt = bump_count(fp_cnt);
    end else begin
      if (p.test_px == bmcs_pkg::PIX_FULL) tn_cnt = bump_count(tn_cnt);
      else                                 fn_cnt = bump_count(fn_cnt);
    end
    if (tp_cnt == bmcs_pkg::COUNT_MAX || fp_cnt == bmcs_pkg::COUNT_MAX ||
        fn_cnt == bmcs_pkg::COUNT_MAX || tn_cnt == bmcs_pkg::COUNT_MAX)
      sat_seen = 1'b1;
    if (!p.last) return;

    tp = tp_cnt;
    fp = fp_cnt;
    fn = fn_cnt;
    tn = tn_cnt;
    s.tp        = bmcs_pkg::CNT_OUT_W'(tp);
    s.fp        = bmcs_pkg::CNT_OUT_W'(fp);
    s.fn        = bmcs_pkg::CNT_OUT_W'(fn);
    s.tn        = bmcs_pkg::CNT_OUT_W'(tn);
    s.acc_undef = (tp + fn == 0) || (tn + fp == 0);
    s.bal_acc   = s.acc_undef ? '0 :
                  bmcs_pkg::RATIO_OUT_W'((q_ratio(tp, tp + fn) + q_ratio(tn, tn + fp)) >> 1);
    s.f1_undef  = (tp == 0);
    s.f1        = s.f1_undef ? '0 :
                  bmcs_pkg::RATIO_OUT_W'(q_ratio(2 * tp, 2 * tp + fp + fn));
    s.saturated = sat_seen;
    expected_stats = {expected_stats, s};

    // The block clears its counters after each frame.
    tp_cnt   = '0;
    fp_cnt   = '0;
    fn_cnt   = '0;
    tn_cnt   = '0;
    sat_seen = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("Frame %0d: %s expected %0d, got %0d", frames_checked, name, want, got);
    end
  endtask

  // Compare one result beat with the oldest pending frame.
  task automatic check_result();
    frame_stats_t want;
    frames_checked++;
    if (expected_stats.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("Frame %0d: result beat with no frame pending", frames_checked);
      return;
    end
    want = expected_stats.pop_front();
    if (want.acc_undef) acc_undef_frames++;
    if (want.f1_undef)  f1_undef_frames++;
    compare_field("true_pos",           32'(want.tp),        32'(res_if.true_pos));
    compare_field("false_pos",          32'(want.fp),        32'(res_if.false_pos));
    compare_field("false_neg",          32'(want.fn),        32'(res_if.false_neg));
    compare_field("true_neg",           32'(want.tn),        32'(res_if.true_neg));
    compare_field("balanced_accuracy",  32'(want.bal_acc),
                  32'(res_if.balanced_accuracy));
    compare_field("f1_score",           32'(want.f1),        32'(res_if.f1_score));
    compare_field("accuracy_undefined", 32'(want.acc_undef),
                  32'(res_if.accuracy_undefined));
    compare_field("f1_undefined",       32'(want.f1_undef),  32'(res_if.f1_undefined));
    compare_field("count_saturated",    32'(want.saturated), 32'(res_if.count_saturated));
  endtask

  // Watch both channels at the rising edge: predict on pixel beats, check result beats.
  always @(posedge clk_i) begin : watch_channels
    pixel_pair_t beat;
    pix_taken = 1'b0;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        beat.ref_px  = pix_if.reference_pixel;
        beat.test_px = pix_if.test_pixel;
        beat.last    = pix_if.frame_end;
        count_pair(beat);
        pixels_counted++;
        pix_taken = 1'b1;
      end else if (pix_if.valid) begin
        input_stall_cycles++;
      end
      if (res_if.valid && res_if.ready) check_result();
      if (res_if.valid && !res_if.ready) begin
        res_wait++;
        if (res_wait > longest_res_wait) longest_res_wait = res_wait;
      end else begin
        res_wait = 0;
      end
    end
  end

  // Pixel driver: bursts of beats separated by random gaps.
  always @(negedge clk_i) begin : drive_pixels
    pixel_pair_t nxt;
    logic        offer;
    if (rst_ni && (!pix_if.valid || pix_taken)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pairs.size() > 0) begin
        nxt   = pending_pairs.pop_front();
        offer = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      pix_if.valid <= offer;
      if (offer) begin
        pix_if.reference_pixel <= nxt.ref_px;
        pix_if.test_pixel      <= nxt.test_px;
        pix_if.frame_end       <= nxt.last;
      end
    end
  end

  // Result receiver: changing ready patterns, plus two long hold-offs mid-stream
  // so that a finished result blocks the next frame end.
  always @(negedge clk_i) begin : pace_results
    logic rdy;
    if (!first_hold_done && frames_checked >= 15) begin
      hold_left       = LONG_HOLD;
      first_hold_done = 1'b1;
    end
    if (!second_hold_done && frames_checked >= 55) begin
      hold_left        = LONG_HOLD;
      second_hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (pace_left == 0) begin
        pace_mode = pace_e'($urandom_range(0, 2));
        pace_left = $urandom_range(20, 150);
      end else begin
        pace_left--;
      end
      case (pace_mode)
        PACE_FULL: rdy = 1'b1;
        PACE_HALF: rdy = 1'($urandom_range(0, 1));
        default:   rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    res_if.ready <= rst_ni && rdy;
  end

  // Run limit.
  always @(posedge clk_i) begin : run_limit
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d frame results outstanding",
               expected_stats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_pair(input logic [bmcs_pkg::PIX_W-1:0] r,
                            input logic [bmcs_pkg::PIX_W-1:0] t,
                            input logic last);
    pixel_pair_t p;
    p.ref_px  = r;
    p.test_px = t;
    p.last    = last;
    pending_pairs = {pending_pairs, p};
  endtask

  // Hold the sender until every queued pixel is taken and every result is back.
  task automatic wait_for_drain();
    while (pending_pairs.size() > 0 || pix_if.valid || expected_stats.size() > 0)
      @(posedge clk_i);
  endtask

  // Frames of random length. Most look like real masks with a chosen share of
  // positives and a chosen error rate; the rest are arbitrary gray values.
  task automatic add_random_frames(input int pixel_target);
    int                         added, len, pos_pct, err_pct;
    frame_style_e               style;
    logic [bmcs_pkg::PIX_W-1:0] r, t;
    added = 0;
    while (added < pixel_target) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(60, 200);
        default: len = $urandom_range(2, 30);
      endcase
      style   = ($urandom_range(0, 9) < 7) ? FRAME_MASK : FRAME_NOISE;
      pos_pct = 25 * $urandom_range(0, 4);
      err_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      for (int i = 0; i < len; i++) begin
        if (style == FRAME_MASK) begin
          if ($urandom_range(1, 100) <= pos_pct) r = bmcs_pkg::PIX_ZERO;
          else if ($urandom_range(0, 7) == 0)    r = bmcs_pkg::PIX_W'($urandom_range(1, 254));
          else                                   r = bmcs_pkg::PIX_FULL;
          if ($urandom_range(1, 100) > err_pct) begin
            t = (r == bmcs_pkg::PIX_ZERO) ? bmcs_pkg::PIX_ZERO : bmcs_pkg::PIX_FULL;
          end else if (r == bmcs_pkg::PIX_ZERO) begin
            t = bmcs_pkg::PIX_W'($urandom_range(1, 255));
          end else if ($urandom_range(0, 1) == 0) begin
            t = bmcs_pkg::PIX_ZERO;
          end else begin
            t = bmcs_pkg::PIX_W'($urandom_range(0, 254));
          end
        end else begin
          r = ($urandom_range(0, 3) == 0) ? bmcs_pkg::PIX_ZERO
                                          : bmcs_pkg::PIX_W'($urandom_range(0, 255));
          t = ($urandom_range(0, 3) == 0) ? bmcs_pkg::PIX_FULL
                                          : bmcs_pkg::PIX_W'($urandom_range(0, 255));
        end
        queue_pair(r, t, i == len - 1);
      end
      added += len;
    end
  endtask

  initial begin : stimulus
    @(posedge rst_ni);

    // Lone-pixel frames, one per bin: each leaves a ratio undefined.
    queue_pair(8'd0,   8'd0,   1'b1);
    queue_pair(8'd0,   8'd255, 1'b1);
    queue_pair(8'd255, 8'd255, 1'b1);
    queue_pair(8'd1,   8'd254, 1'b1);
    // One pixel in each bin: both ratios one half.
    queue_pair(8'd0,   8'd0,   1'b0);
    queue_pair(8'd0,   8'd128, 1'b0);
    queue_pair(8'd7,   8'd255, 1'b0);
    queue_pair(8'd255, 8'd1,   1'b1);
    // Perfect match: both ratios exactly one.
    queue_pair(8'd0,   8'd0,   1'b0);
    queue_pair(8'd128, 8'd255, 1'b1);
    // No negatives found correctly or wrongly: accuracy undefined, F1 defined.
    queue_pair(8'd0,   8'd0,   1'b0);
    queue_pair(8'd255, 8'd0,   1'b0);
    queue_pair(8'd1,   8'd0,   1'b1);
    // Uneven ratios with truncation.
    queue_pair(8'd0,   8'd0,   1'b0);
    queue_pair(8'd0,   8'd0,   1'b0);
    queue_pair(8'd0,   8'd1,   1'b0);
    queue_pair(8'd254, 8'd255, 1'b1);
    // No true positives, in two frames: F1 undefined, accuracy still defined.
    queue_pair(8'd0,   8'd255, 1'b0);
    queue_pair(8'd200, 8'd127, 1'b0);
    queue_pair(8'd170, 8'd255, 1'b1);
    queue_pair(8'd85,  8'd170, 1'b0);
    queue_pair(8'd0,   8'd85,  1'b1);
    wait_for_drain();

    add_random_frames(RANDOM_PIXELS / 2);
    wait_for_drain();
    add_random_frames(RANDOM_PIXELS - RANDOM_PIXELS / 2);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_stats.size() > 0) begin
      $display("%0d frame results never arrived", expected_stats.size());
      mismatches += expected_stats.size();
    end
    $display("Checked %0d frame results over %0d pixel beats (%0d with accuracy undefined,",
             frames_checked, pixels_counted, acc_undef_frames);
    $display("%0d with F1 undefined); input held off %0d cycles, longest result wait %0d.",
             f1_undef_frames, input_stall_cycles, longest_res_wait);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    tp_cnt             = '0;
    fp_cnt             = '0;
    fn_cnt             = '0;
    tn_cnt             = '0;
    sat_seen           = 1'b0;
    mismatches         = 0;
    frames_checked     = 0;
    pixels_counted     = 0;
    cycle_count        = 0;
    acc_undef_frames   = 0;
    f1_undef_frames    = 0;
    input_stall_cycles = 0;
    res_wait           = 0;
    longest_res_wait   = 0;
    burst_left         = 0;
    gap_left           = 0;
    hold_left          = 0;
    pace_left          = 0;
    pix_taken          = 1'b0;
    first_hold_done    = 1'b0;
    second_hold_done   = 1'b0;
    pace_mode          = PACE_FULL;
  end

endmodule
